// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge of clk, disabled while rst_n is low
`define MPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// condition that must never be seen on a rising edge of clk
`define MPQ_NEVER(lbl, clk, rst_n, cond, msg) \
    `MPQ_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

// ===== rtl/mpq_pkg.sv =====
package mpq_pkg;

    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 64;

    localparam int CFG_W    = 7;
    localparam int COUNT_W  = 13;
    localparam int COORD_W  = 8;
    localparam int PIX_W    = 8;
    localparam int RADIUS_W = 16;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [CFG_W-1:0] MASK_WIDTH_RST  = 7'd64;
    localparam logic [CFG_W-1:0] MASK_HEIGHT_RST = 7'd64;

    // register index, taken from paddr[2]
    localparam logic REG_MASK_WIDTH  = 1'b0;
    localparam logic REG_MASK_HEIGHT = 1'b1;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LD_RD,
        ST_LD_WR,
        ST_Q_SETUP,
        ST_Q_SCAN,
        ST_Q_DRAIN,
        ST_FINISH
    } state_t;

endpackage

// ===== rtl/mpq_ram.sv =====
module mpq_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/mask_proximity_query_core.sv =====
// Binary mask store with a proximity search. After reset the block clears the
// MAX_WIDTH*MAX_HEIGHT entry mask memory one entry per cycle and takes no
// request until that pass is done; register writes are taken at any time. A load
// request reads the old bit, then writes the new bit with the count update; a
// load outside the area in use skips the write. A query request, after a setup
// step, scans the square window of radius ceil(distance), clipped to the mask
// area in use, reading one pixel per cycle through the single read port of the
// mask memory, and then drains the read and distance pipeline; the window holds
// at most the area in use (4096 pixels at 64 by 64). The scan stops early at the
// first set pixel found within distance. In every case the result is presented
// in the same cycle in which the next request can first be taken, and a result
// stalled by the receiver holds the block in its finish state until the output
// register is free. One result waits in an output register while the next
// request is accepted.
`include "assert_macros.svh"

module mask_proximity_query_core
    import mpq_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [PADDR_W-1:0]         paddr,
    input  logic [PDATA_W-1:0]         pwdata,
    output logic [PDATA_W-1:0]         prdata,
    output logic                       pready,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_cmd,
    input  logic signed [COORD_W-1:0]  s_pos_x,
    input  logic signed [COORD_W-1:0]  s_pos_y,
    input  logic [PIX_W-1:0]           s_pixel_value,
    input  logic [RADIUS_W-1:0]        s_radius_q8,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_near_found,
    output logic [COUNT_W-1:0]         m_valid_count
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam logic [AW-1:0] CLEAR_LAST = AW'(DEPTH - 1);

    state_t state_reg, state_next;

    logic [CFG_W-1:0]   mask_width_reg, mask_width_next;
    logic [CFG_W-1:0]   mask_height_reg, mask_height_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [AW-1:0]      clr_cnt_reg, clr_cnt_next;
    logic               found_reg, found_next;
    logic               m_valid_reg, m_valid_next;
    logic               p1_vld_reg, p1_vld_next;
    logic               p2_vld_reg, p2_vld_next;

    logic signed [COORD_W-1:0] px_reg, px_next;
    logic signed [COORD_W-1:0] py_reg, py_next;
    logic                      pv_set_reg, pv_set_next;
    logic [RADIUS_W-1:0]       r_reg, r_next;
    logic [31:0]               r2_reg, r2_next;
    logic [XW-1:0]             x_lo_reg, x_lo_next, x_hi_reg, x_hi_next;
    logic [YW-1:0]             y_lo_reg, y_lo_next, y_hi_reg, y_hi_next;
    logic [XW-1:0]             x_cnt_reg, x_cnt_next;
    logic [YW-1:0]             y_cnt_reg, y_cnt_next;
    logic [XW-1:0]             p1_x_reg, p1_x_next;
    logic [YW-1:0]             p1_y_reg, p1_y_next;
    logic                      p2_bit_reg, p2_bit_next;
    logic [15:0]               sq_x_reg, sq_x_next, sq_y_reg, sq_y_next;
    logic                      m_near_reg, m_near_next;
    logic [COUNT_W-1:0]        m_count_reg, m_count_next;

    logic [CFG_W-1:0] w_use, h_use;
    logic             cfg_wr;
    logic             ld_ok;
    logic [AW-1:0]    ld_addr, scan_addr;
    logic             mem_we, mem_wdata;
    logic [AW-1:0]    mem_waddr, mem_raddr;
    logic [0:0]       mem_rdata;
    logic             issue, scan_last, hit, out_free, scanning;

    logic [8:0]         rc;
    logic signed [10:0] px_s, py_s, rc_s;
    logic signed [10:0] x_lo_s, x_hi_s, y_lo_s, y_hi_s;
    logic signed [10:0] x_lo_c, x_hi_c, y_lo_c, y_hi_c;
    logic signed [10:0] w_max_s, h_max_s;
    logic               win_empty;

    logic signed [9:0]  dx, dy;
    logic signed [19:0] dx_sq, dy_sq;
    logic [16:0]        d2;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_MASK_HEIGHT) ? PDATA_W'(mask_height_reg)
                                                  : PDATA_W'(mask_width_reg);

    // area in use, limited by the store
    assign w_use = (int'(mask_width_reg) > MAX_WIDTH) ? CFG_W'(MAX_WIDTH) : mask_width_reg;
    assign h_use = (int'(mask_height_reg) > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT) : mask_height_reg;

    assign ld_ok = !px_reg[COORD_W-1] && !py_reg[COORD_W-1]
                && (px_reg[6:0] < w_use) && (py_reg[6:0] < h_use);

    assign ld_addr   = AW'(AW'(py_reg[6:0]) * AW'(MAX_WIDTH)) + AW'(px_reg[6:0]);
    assign scan_addr = AW'(AW'(y_cnt_reg) * AW'(MAX_WIDTH)) + AW'(x_cnt_reg);

    // query window, radius ceil(distance), clipped to the area in use
    always_comb begin
        rc      = 9'((17'(r_reg) + 17'd255) >> 8);
        rc_s    = $signed({2'b00, rc});
        px_s    = 11'(px_reg);
        py_s    = 11'(py_reg);
        x_lo_s  = px_s - rc_s;
        x_hi_s  = px_s + rc_s;
        y_lo_s  = py_s - rc_s;
        y_hi_s  = py_s + rc_s;
        w_max_s = $signed(11'(w_use)) - 11'sd1;
        h_max_s = $signed(11'(h_use)) - 11'sd1;
        x_lo_c  = (x_lo_s < 11'sd0) ? 11'sd0 : x_lo_s;
        y_lo_c  = (y_lo_s < 11'sd0) ? 11'sd0 : y_lo_s;
        x_hi_c  = (x_hi_s > w_max_s) ? w_max_s : x_hi_s;
        y_hi_c  = (y_hi_s > h_max_s) ? h_max_s : y_hi_s;
        win_empty = (w_use == '0) || (h_use == '0)
                 || (x_lo_c > x_hi_c) || (y_lo_c > y_hi_c);
    end

    // distance pipeline: squares after the read, compare one stage later
    always_comb begin
        dx    = $signed(10'(p1_x_reg)) - 10'(px_reg);
        dy    = $signed(10'(p1_y_reg)) - 10'(py_reg);
        dx_sq = dx * dx;
        dy_sq = dy * dy;
        d2    = 17'(sq_x_reg) + 17'(sq_y_reg);
        hit   = p2_vld_reg && p2_bit_reg && ({d2, 16'h0000} < {1'b0, r2_reg});
    end

    assign scanning  = (state_reg == ST_Q_SCAN) || (state_reg == ST_Q_DRAIN);
    assign scan_last = (x_cnt_reg == x_hi_reg) && (y_cnt_reg == y_hi_reg);
    assign out_free  = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == CLEAR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_cmd == CMD_QUERY) ? ST_Q_SETUP : ST_LD_RD;
                end
            end
            ST_LD_RD: begin
                state_next = ld_ok ? ST_LD_WR : ST_FINISH;
            end
            ST_LD_WR: begin
                state_next = ST_FINISH;
            end
            ST_Q_SETUP: begin
                state_next = win_empty ? ST_FINISH : ST_Q_SCAN;
            end
            ST_Q_SCAN: begin
                if (hit) begin
                    state_next = ST_FINISH;
                end else if (scan_last) begin
                    state_next = ST_Q_DRAIN;
                end
            end
            ST_Q_DRAIN: begin
                if (hit || (!p1_vld_reg && !p2_vld_reg)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // state outputs
    always_comb begin
        s_ready   = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = ld_addr;
        mem_wdata = pv_set_reg;
        mem_raddr = scan_addr;
        issue     = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = 1'b0;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_LD_RD: begin
                mem_raddr = ld_addr;
            end
            ST_LD_WR: begin
                mem_we = 1'b1;
            end
            ST_Q_SCAN: begin
                issue = !hit;
            end
            default: begin
            end
        endcase
    end

    // datapath next values
    always_comb begin
        mask_width_next  = mask_width_reg;
        mask_height_next = mask_height_reg;
        count_next       = count_reg;
        clr_cnt_next     = clr_cnt_reg;
        found_next       = found_reg;
        m_valid_next     = m_valid_reg;
        px_next          = px_reg;
        py_next          = py_reg;
        pv_set_next      = pv_set_reg;
        r_next           = r_reg;
        r2_next          = r2_reg;
        x_lo_next        = x_lo_reg;
        x_hi_next        = x_hi_reg;
        y_lo_next        = y_lo_reg;
        y_hi_next        = y_hi_reg;
        x_cnt_next       = x_cnt_reg;
        y_cnt_next       = y_cnt_reg;
        m_near_next      = m_near_reg;
        m_count_next     = m_count_reg;

        p1_vld_next = issue;
        p1_x_next   = x_cnt_reg;
        p1_y_next   = y_cnt_reg;
        p2_vld_next = p1_vld_reg && scanning && !hit;
        p2_bit_next = mem_rdata[0];
        sq_x_next   = 16'(dx_sq);
        sq_y_next   = 16'(dy_sq);

        if (cfg_wr) begin
            if (paddr[2] == REG_MASK_HEIGHT) begin
                mask_height_next = pwdata[CFG_W-1:0];
            end else begin
                mask_width_next = pwdata[CFG_W-1:0];
            end
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
            end
            ST_IDLE: begin
                if (s_valid) begin
                    px_next     = s_pos_x;
                    py_next     = s_pos_y;
                    pv_set_next = |s_pixel_value;
                    r_next      = s_radius_q8;
                    found_next  = 1'b0;
                end
            end
            ST_LD_WR: begin
                // old bit is on the read port now
                if (pv_set_reg && !mem_rdata[0]) begin
                    count_next = count_reg + COUNT_W'(1);
                end else if (!pv_set_reg && mem_rdata[0]) begin
                    count_next = count_reg - COUNT_W'(1);
                end
            end
            ST_Q_SETUP: begin
                r2_next    = 32'(r_reg) * 32'(r_reg);
                x_lo_next  = XW'(x_lo_c);
                x_hi_next  = XW'(x_hi_c);
                y_lo_next  = YW'(y_lo_c);
                y_hi_next  = YW'(y_hi_c);
                x_cnt_next = XW'(x_lo_c);
                y_cnt_next = YW'(y_lo_c);
            end
            ST_Q_SCAN: begin
                if (hit) begin
                    found_next = 1'b1;
                end
                if (issue) begin
                    if (x_cnt_reg == x_hi_reg) begin
                        x_cnt_next = x_lo_reg;
                        y_cnt_next = y_cnt_reg + YW'(1);
                    end else begin
                        x_cnt_next = x_cnt_reg + XW'(1);
                    end
                end
            end
            ST_Q_DRAIN: begin
                if (hit) begin
                    found_next = 1'b1;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_near_next  = found_reg;
                    m_count_next = count_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            mask_width_reg  <= MASK_WIDTH_RST;
            mask_height_reg <= MASK_HEIGHT_RST;
            count_reg       <= '0;
            clr_cnt_reg     <= '0;
            found_reg       <= 1'b0;
            m_valid_reg     <= 1'b0;
            p1_vld_reg      <= 1'b0;
            p2_vld_reg      <= 1'b0;
        end else begin
            state_reg       <= state_next;
            mask_width_reg  <= mask_width_next;
            mask_height_reg <= mask_height_next;
            count_reg       <= count_next;
            clr_cnt_reg     <= clr_cnt_next;
            found_reg       <= found_next;
            m_valid_reg     <= m_valid_next;
            p1_vld_reg      <= p1_vld_next;
            p2_vld_reg      <= p2_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        px_reg      <= px_next;
        py_reg      <= py_next;
        pv_set_reg  <= pv_set_next;
        r_reg       <= r_next;
        r2_reg      <= r2_next;
        x_lo_reg    <= x_lo_next;
        x_hi_reg    <= x_hi_next;
        y_lo_reg    <= y_lo_next;
        y_hi_reg    <= y_hi_next;
        x_cnt_reg   <= x_cnt_next;
        y_cnt_reg   <= y_cnt_next;
        p1_x_reg    <= p1_x_next;
        p1_y_reg    <= p1_y_next;
        p2_bit_reg  <= p2_bit_next;
        sq_x_reg    <= sq_x_next;
        sq_y_reg    <= sq_y_next;
        m_near_reg  <= m_near_next;
        m_count_reg <= m_count_next;
    end

    mpq_ram #(
        .WIDTH(1),
        .DEPTH(DEPTH)
    ) u_mask_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign m_valid       = m_valid_reg;
    assign m_near_found  = m_near_reg;
    assign m_valid_count = m_count_reg;

    `MPQ_ASSERT(a_count_hold, aclk, aresetn, state_reg != ST_LD_WR |=> count_reg == $past(count_reg), "count changed outside a load write")
    `MPQ_ASSERT(a_count_step, aclk, aresetn, state_reg == ST_LD_WR |=> (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + 13'd1) || (count_reg == $past(count_reg) - 13'd1), "count moved by more than one")
    `MPQ_NEVER(a_write_state, aclk, aresetn, mem_we && !(state_reg == ST_CLEAR || state_reg == ST_LD_WR), "mask write outside clear or load")
    `MPQ_ASSERT(a_scan_window, aclk, aresetn, state_reg == ST_Q_SCAN |-> x_cnt_reg >= x_lo_reg && x_cnt_reg <= x_hi_reg && y_cnt_reg >= y_lo_reg && y_cnt_reg <= y_hi_reg, "scan left its window")
    `MPQ_ASSERT(a_finish_out, aclk, aresetn, state_reg == ST_FINISH && out_free |=> m_valid_reg, "finished request left no result")

endmodule

// ===== sim/tb_mask_proximity_query_core.sv =====
`timescale 1ns / 100ps

module tb_mask_proximity_query_core;
    import mpq_pkg::*;

    // expected answers, kept in request order
    class mask_scoreboard;
        typedef struct {
            logic               near;
            logic [COUNT_W-1:0] count;
        } mask_answer_t;

        bit                 mask_bits [MAX_WIDTH_DEF*MAX_HEIGHT_DEF];
        logic [COUNT_W-1:0] set_count;
        int                 cols;
        int                 rows;
        int                 errors;
        mask_answer_t       pending_answers [$];

        function new();
            foreach (mask_bits[i]) mask_bits[i] = 1'b0;
            set_count = '0;
            errors    = 0;
            resize(MASK_WIDTH_RST, MASK_HEIGHT_RST);
        endfunction

        // sizes beyond the store clip to the store
        function void resize(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
            cols = (w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(w);
            rows = (h > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(h);
        endfunction

        function bit any_set_within(int px, int py, longint r);
            longint dx, dy;
            for (int y = 0; y < rows; y++) begin
                for (int x = 0; x < cols; x++) begin
                    if (mask_bits[y*MAX_WIDTH_DEF + x]) begin
                        dx = x - px;
                        dy = y - py;
                        if ((dx*dx + dy*dy) * 65536 < r*r) return 1'b1;
                    end
                end
            end
            return 1'b0;
        endfunction

        function void note_request(logic cmd, int px, int py, logic [PIX_W-1:0] pv,
                                   logic [RADIUS_W-1:0] r);
            mask_answer_t a;
            int           idx;
            a.near = 1'b0;
            if (cmd == CMD_QUERY) begin
                a.near = any_set_within(px, py, longint'(r));
            end else if (px >= 0 && py >= 0 && px < cols && py < rows) begin
                idx = py*MAX_WIDTH_DEF + px;
                if (pv != 0 && !mask_bits[idx]) set_count++;
                else if (pv == 0 && mask_bits[idx]) set_count--;
                mask_bits[idx] = (pv != 0);
            end
            a.count = set_count;
            pending_answers.push_back(a);
        endfunction

        function int pending();
            return pending_answers.size();
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch at %0t: %s", $time, msg);
        endtask

        task check_result(logic near, logic [COUNT_W-1:0] count);
            mask_answer_t a;
            if (pending_answers.size() == 0) begin
                report("result with no request outstanding");
                return;
            end
            a = pending_answers.pop_front();
            if (near !== a.near)
                report($sformatf("near_found %b, expected %b", near, a.near));
            if (count !== a.count)
                report($sformatf("valid_count %0d, expected %0d", count, a.count));
        endtask
    endclass

    logic                       aclk;
    logic                       aresetn;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [PADDR_W-1:0]         paddr;
    logic [PDATA_W-1:0]         pwdata;
    logic [PDATA_W-1:0]         prdata;
    logic                       pready;
    logic                       s_valid;
    logic                       s_ready;
    logic                       s_cmd;
    logic signed [COORD_W-1:0]  s_pos_x;
    logic signed [COORD_W-1:0]  s_pos_y;
    logic [PIX_W-1:0]           s_pixel_value;
    logic [RADIUS_W-1:0]        s_radius_q8;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic                       m_near_found;
    logic [COUNT_W-1:0]         m_valid_count;

    mask_scoreboard sb = new();
    int             send_idle_pct;
    int             recv_idle_pct;
    int             last_set_x;
    int             last_set_y;

    mask_proximity_query_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_pos_x       (s_pos_x),
        .s_pos_y       (s_pos_y),
        .s_pixel_value (s_pixel_value),
        .s_radius_q8   (s_radius_q8),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_near_found  (m_near_found),
        .m_valid_count (m_valid_count)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_request(s_cmd, int'(s_pos_x), int'(s_pos_y), s_pixel_value,
                                s_radius_q8);
            if (m_valid && m_ready)
                sb.check_result(m_near_found, m_valid_count);
        end
    end

    task automatic send_request(input logic cmd, input logic signed [COORD_W-1:0] x,
                                input logic signed [COORD_W-1:0] y,
                                input logic [PIX_W-1:0] pv, input logic [RADIUS_W-1:0] r);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid       <= 1'b1;
        s_cmd         <= cmd;
        s_pos_x       <= x;
        s_pos_y       <= y;
        s_pixel_value <= pv;
        s_radius_q8   <= r;
        do @(posedge aclk); while (!s_ready);
    endtask

    // one edge first so the monitor has seen the last accepted request
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    // back-to-back transfers keep psel high; the caller closes the bus
    task automatic apb_write(input logic idx, input logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= (32'($urandom) & ~32'h7F) | 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
    endtask

    task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        wait_drained();
        apb_write(REG_MASK_WIDTH, w);
        apb_write(REG_MASK_HEIGHT, h);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.resize(w, h);
    endtask

    // mostly loads inside the area and queries around recently set pixels
    task automatic send_random_item();
        int                        pick;
        int                        pr;
        logic                      c;
        logic signed [COORD_W-1:0] x, y;
        logic [PIX_W-1:0]          v;
        logic [RADIUS_W-1:0]       r;
        c    = ($urandom_range(99) < 45) ? CMD_QUERY : CMD_LOAD;
        pick = $urandom_range(99);
        if (pick < 20 || sb.cols == 0 || sb.rows == 0) begin
            x = COORD_W'($urandom_range(255));
            y = COORD_W'($urandom_range(255));
        end else if (c == CMD_QUERY && pick < 60) begin
            x = COORD_W'(last_set_x + int'($urandom_range(4)) - 2);
            y = COORD_W'(last_set_y + int'($urandom_range(4)) - 2);
        end else begin
            x = COORD_W'($urandom_range(sb.cols - 1, 0));
            y = COORD_W'($urandom_range(sb.rows - 1, 0));
        end
        v  = ($urandom_range(99) < 35) ? '0 : PIX_W'($urandom_range(255, 1));
        pr = $urandom_range(99);
        if (pr < 60) r = RADIUS_W'($urandom_range(1024));
        else if (pr < 85) r = RADIUS_W'($urandom_range(4096));
        else r = RADIUS_W'($urandom_range(65535));
        if (c == CMD_LOAD && v != 0) begin
            last_set_x = int'(x);
            last_set_y = int'(y);
        end
        send_request(c, x, y, v, r);
    endtask

    task automatic run_phase(input int w, input int h, input int count);
        set_size(CFG_W'(w), CFG_W'(h));
        repeat (count) send_random_item();
    endtask

    initial begin
        aresetn       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_valid       = 1'b0;
        s_cmd         = CMD_LOAD;
        s_pos_x       = '0;
        s_pos_y       = '0;
        s_pixel_value = '0;
        s_radius_q8   = '0;
        send_idle_pct = 14;
        recv_idle_pct = 86;
        last_set_x    = 0;
        last_set_y    = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // reset size, empty mask first
        send_request(CMD_QUERY, 0, 0, 8'h00, 16'hFFFF);
        send_request(CMD_LOAD, 0, 0, 8'hFF, 16'h0000);
        send_request(CMD_LOAD, 63, 63, 8'h01, 16'hFFFF);
        send_request(CMD_LOAD, 63, 0, 8'h80, 16'h0000);
        send_request(CMD_LOAD, 0, 0, 8'h07, 16'h0000);
        // loads outside the area are dropped
        send_request(CMD_LOAD, -1, 5, 8'hFF, 16'h0000);
        send_request(CMD_LOAD, 64, 0, 8'hFF, 16'h0000);
        send_request(CMD_LOAD, 0, 64, 8'hFF, 16'h0000);
        send_request(CMD_LOAD, -128, -128, 8'hFF, 16'h0000);
        send_request(CMD_LOAD, 127, 127, 8'hFF, 16'h0000);
        // zero distance, then the strict boundary at exactly two pixels
        send_request(CMD_QUERY, 0, 0, 8'h00, 16'h0000);
        send_request(CMD_QUERY, 0, 0, 8'h00, 16'h0001);
        send_request(CMD_QUERY, 2, 0, 8'h00, 16'h0200);
        send_request(CMD_QUERY, 2, 0, 8'h00, 16'h0201);
        send_request(CMD_QUERY, -128, -128, 8'hFF, 16'hFFFF);
        send_request(CMD_QUERY, 127, 127, 8'h00, 16'hFFFF);
        send_request(CMD_QUERY, 127, -128, 8'h00, 16'h00FF);
        send_request(CMD_LOAD, 0, 0, 8'h00, 16'h0000);
        send_request(CMD_LOAD, 63, 63, 8'h00, 16'h0000);
        // shrink: (63,0) stays counted but is no longer searched
        set_size(7'd1, 7'd1);
        send_request(CMD_QUERY, 63, 0, 8'h00, 16'hFFFF);
        send_request(CMD_LOAD, 0, 0, 8'hFF, 16'h0000);
        send_request(CMD_QUERY, 63, 0, 8'h00, 16'hFFFF);
        set_size(7'd0, 7'd64);
        send_request(CMD_LOAD, 0, 0, 8'h00, 16'h0000);
        send_request(CMD_QUERY, 0, 0, 8'h00, 16'hFFFF);

        run_phase(8, 8, 22);
        run_phase(1, 64, 14);
        send_idle_pct = 86;
        recv_idle_pct = 14;
        run_phase(127, 127, 20);
        run_phase(0, 20, 8);
        run_phase(64, 1, 14);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (3) run_phase($urandom_range(16, 1), $urandom_range(16, 1), 13);

        wait_drained();
        repeat (64) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
